### rtl/core/bilinear_fade_filter_top_defines.svh
// Assertion macros shared by the bilinear fade filter RTL.
`ifndef BILINEAR_FADE_FILTER_TOP_DEFINES_SVH
`define BILINEAR_FADE_FILTER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BFF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BFF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bff_pkg.sv
// Types, constants and blend arithmetic for the bilinear fade filter.
`default_nettype none

package bff_pkg;

    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 3;
    localparam int LINE_W  = 10;
    localparam int WEIGHT_W = 9;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [LINE_W-1:0]   LINE_WIDTH_RST = 10'd448;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = 9'd50;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 9'd256;
    localparam int                  WIDTH_MIN      = 2;

    localparam logic [1:0] REG_LINE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_WEIGHT_ACROSS = 2'd1;
    localparam logic [1:0] REG_WEIGHT_DOWN   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOP,
        ST_DOWN
    } t_state;

    typedef logic [CHAN_W-1:0] t_chan;

    function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
        return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
    endfunction

    // floor((b - a) * w / 256) + a
    function automatic t_chan lerp(input t_chan a, input t_chan b,
                                   input logic [WEIGHT_W-1:0] w);
        logic signed [9:0]  diff;
        logic signed [9:0]  wt;
        logic signed [19:0] prod;
        logic [7:0]         frac;
        diff = $signed({2'b00, b}) - $signed({2'b00, a});
        wt   = $signed({1'b0, w});
        prod = diff * wt;
        frac = prod[15:8];
        return frac + a;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bff_intf.sv
// Valid/ready stream interfaces for the pixel input and blended output channels.
`default_nettype none

interface bff_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bff_pkg::PIX_W-1:0] pixel_color;
    logic                      start_of_frame;
    logic                      end_of_frame;

    modport source (output valid, output pixel_color, output start_of_frame,
                    output end_of_frame, input ready);
    modport sink (input valid, input pixel_color, input start_of_frame,
                  input end_of_frame, output ready);
endinterface

interface bff_res_if;
    logic                      valid;
    logic                      ready;
    logic [bff_pkg::PIX_W-1:0] blended_color;
    logic                      last_of_frame;

    modport source (output valid, output blended_color, output last_of_frame,
                    input ready);
    modport sink (input valid, input blended_color, input last_of_frame,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/bff_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none

module bff_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 513
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### rtl/core/bilinear_fade_filter_top.sv
// Bilinear fade filter: 2x2 weighted blend over a raster pixel stream.
//
// Usage:
//   i_pix carries pixels 0xRRGGBB in raster order with start/end of frame flags.
//   o_res carries one blended pixel for each input pixel whose index n in the
//   frame exceeds the row width W; it is the blend of pixel n-W-1.
//   APB port: line_width at 0x0, weight_across at 0x4, weight_down at 0x8.
//   Write registers only while the block is idle.
// Timing:
//   A pixel is taken only when idle, then passes through accept, horizontal
//   blend and vertical blend before the next one is taken. The line buffer
//   RAM read for the pixels a row back is issued in the accept cycle and
//   returns in the cycle after. A result is loaded at the end of the vertical blend.
// Reset:
//   Registers return to width 448 and weights 50; the fill count clears, so
//   no result appears before a full row plus one pixel is seen.
//   The line buffer is not cleared.
// Stall:
//   A result waits in the output register; the next pixel is still accepted
//   and its blend holds in the last stage until the output register frees.
`default_nettype none
`include "bilinear_fade_filter_top_defines.svh"

module bilinear_fade_filter_top #(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    bff_pix_if.sink                           i_pix,
    bff_res_if.source                         o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bff_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bff_pkg::APB_DW-1:0]   pwdata,
    output logic      [bff_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    localparam int DEPTH = MAX_WIDTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int EW    = ((CW > bff_pkg::LINE_W) ? CW : bff_pkg::LINE_W) + 1;
    localparam int PW    = bff_pkg::PIX_W;
    localparam int CH    = bff_pkg::CHAN_W;

    // Configuration registers
    logic [bff_pkg::LINE_W-1:0]   r_line_width;
    logic [bff_pkg::WEIGHT_W-1:0] r_weight_across;
    logic [bff_pkg::WEIGHT_W-1:0] r_weight_down;
    logic                         cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width    <= bff_pkg::LINE_WIDTH_RST;
            r_weight_across <= bff_pkg::WEIGHT_RST;
            r_weight_down   <= bff_pkg::WEIGHT_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                bff_pkg::REG_LINE_WIDTH:    r_line_width    <= pwdata[bff_pkg::LINE_W-1:0];
                bff_pkg::REG_WEIGHT_ACROSS: r_weight_across <= pwdata[bff_pkg::WEIGHT_W-1:0];
                bff_pkg::REG_WEIGHT_DOWN:   r_weight_down   <= pwdata[bff_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bff_pkg::REG_LINE_WIDTH:    prdata = bff_pkg::APB_DW'(r_line_width);
            bff_pkg::REG_WEIGHT_ACROSS: prdata = bff_pkg::APB_DW'(r_weight_across);
            bff_pkg::REG_WEIGHT_DOWN:   prdata = bff_pkg::APB_DW'(r_weight_down);
            default:                    prdata = '0;
        endcase
    end

    // Effective width and weights
    logic [EW-1:0]                lw_ext;
    logic [EW-1:0]                lw_sat;
    logic [CW-1:0]                eff_w;
    logic [bff_pkg::WEIGHT_W-1:0] wa;
    logic [bff_pkg::WEIGHT_W-1:0] wd;

    always_comb begin
        lw_ext = EW'(r_line_width);
        lw_sat = lw_ext;
        if (lw_ext < EW'(bff_pkg::WIDTH_MIN)) begin
            lw_sat = EW'(bff_pkg::WIDTH_MIN);
        end else if (lw_ext > EW'(MAX_WIDTH)) begin
            lw_sat = EW'(MAX_WIDTH);
        end
        eff_w = CW'(lw_sat);
    end

    assign wa = bff_pkg::sat_weight(r_weight_across);
    assign wd = bff_pkg::sat_weight(r_weight_down);

    // Control and datapath state
    bff_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_fill;
    logic [AW-1:0]   r_wp;
    logic [PW-1:0]   r_prev;
    logic [PW-1:0]   r_cur;
    logic [PW-1:0]   r_p10;
    logic            r_eof;
    logic            r_emit;
    bff_pkg::t_chan  r_top [bff_pkg::NCHAN];
    bff_pkg::t_chan  r_bot [bff_pkg::NCHAN];
    logic            r_out_valid, n_out_valid;
    logic [PW-1:0]   r_out_color;
    logic            r_out_last;

    logic            accept;
    logic            load_out;
    logic            ld_top;
    logic [CW-1:0]   n_idx;
    logic [SW-1:0]   sum_a;
    logic [SW-1:0]   sum_b;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    logic [PW-1:0]   rdata_a;
    logic [PW-1:0]   rdata_b;
    logic [PW-1:0]   blend;

    assign i_pix.ready = (r_state == bff_pkg::ST_IDLE);
    assign accept      = i_pix.valid && i_pix.ready;
    assign n_idx       = i_pix.start_of_frame ? '0 : r_fill;

    // Addresses of the pixels W+1 and W beats back
    always_comb begin
        sum_a = SW'(r_wp) + SW'(DEPTH) - SW'(eff_w) - SW'(1);
        sum_b = SW'(r_wp) + SW'(DEPTH) - SW'(eff_w);
        if (sum_a >= SW'(DEPTH)) begin
            sum_a = sum_a - SW'(DEPTH);
        end
        if (sum_b >= SW'(DEPTH)) begin
            sum_b = sum_b - SW'(DEPTH);
        end
        raddr_a = AW'(sum_a);
        raddr_b = AW'(sum_b);
    end

    bff_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (r_wp),
        .i_wdata   (i_pix.pixel_color),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bff_pkg::ST_IDLE;
            r_fill      <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_fill <= (n_idx < CW'(DEPTH)) ? n_idx + CW'(1) : CW'(DEPTH);
                r_wp   <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p10  <= r_prev;
            r_prev <= i_pix.pixel_color;
            r_cur  <= i_pix.pixel_color;
            r_eof  <= i_pix.end_of_frame;
            r_emit <= (n_idx > eff_w);
        end
        if (ld_top) begin
            for (int c = 0; c < bff_pkg::NCHAN; c++) begin
                r_top[c] <= bff_pkg::lerp(rdata_a[c*CH +: CH], rdata_b[c*CH +: CH], wa);
                r_bot[c] <= bff_pkg::lerp(r_p10[c*CH +: CH], r_cur[c*CH +: CH], wa);
            end
        end
        if (load_out) begin
            r_out_color <= blend;
            r_out_last  <= r_eof;
        end
    end

    always_comb begin
        for (int c = 0; c < bff_pkg::NCHAN; c++) begin
            blend[c*CH +: CH] = bff_pkg::lerp(r_top[c], r_bot[c], wd);
        end
    end

    always_comb begin
        n_state     = r_state;
        ld_top      = 1'b0;
        load_out    = 1'b0;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            bff_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = bff_pkg::ST_TOP;
                end
            end
            bff_pkg::ST_TOP: begin
                ld_top  = 1'b1;
                n_state = bff_pkg::ST_DOWN;
            end
            bff_pkg::ST_DOWN: begin
                if (!r_emit) begin
                    n_state = bff_pkg::ST_IDLE;
                end else if (!r_out_valid || o_res.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = bff_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bff_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.blended_color = r_out_color;
    assign o_res.last_of_frame = r_out_last;

    `BFF_ASSERT_IMP(a_wr_rd_apart, i_clk, i_rst_n, accept, r_wp != raddr_b, "line buffer write collides with the near read")
    `BFF_ASSERT_NXT(a_accept_to_top, i_clk, i_rst_n, accept, r_state == bff_pkg::ST_TOP, "accepted beat did not advance to blend")
    `BFF_ASSERT_IMP(a_out_from_down, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == bff_pkg::ST_DOWN, "result appeared outside the final stage")
    `BFF_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(DEPTH), "fill count beyond line depth")

endmodule

`default_nettype wire
